@@ sv/gbn_pkg.sv @@
package gbn_pkg;

  localparam int SEQ_COUNT = 8;
  localparam int SEQ_BITS  = 3;
  localparam int TIME_BITS = 16;
  localparam int PKT_BITS  = 16;
  localparam int WIN_BITS  = 3;
  localparam int CFG_BITS  = 16;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] KIND_SEND    = 3'd0;
  localparam logic [2:0] KIND_RESEND  = 3'd1;
  localparam logic [2:0] KIND_ACKED   = 3'd2;
  localparam logic [2:0] KIND_IGNORED = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [WIN_BITS-1:0]  WINDOW_RESET  = 3'd7;
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 16'd5;

  typedef struct packed {
    logic                 pkt_we;
    logic                 start_we;
    logic                 timing_set;
    logic                 timing_clr;
    logic [SEQ_BITS-1:0]  waddr;
    logic [SEQ_BITS-1:0]  raddr;
    logic [PKT_BITS-1:0]  wpkt;
    logic [TIME_BITS-1:0] wstart;
  } mem_ctl_t;

endpackage

@@ sv/gbn_slot_mem.sv @@
module gbn_slot_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  gbn_pkg::mem_ctl_t             ctl,
  output logic [gbn_pkg::PKT_BITS-1:0]  rd_pkt,
  output logic [gbn_pkg::TIME_BITS-1:0] rd_start,
  output logic                          rd_timing
);
  import gbn_pkg::*;

  logic [PKT_BITS-1:0]  pkt_mem   [SEQ_COUNT];
  logic [TIME_BITS-1:0] start_mem [SEQ_COUNT];
  logic [SEQ_COUNT-1:0] timing;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing <= '0;
    end else begin
      if (ctl.timing_set) begin
        timing[ctl.waddr] <= 1'b1;
      end
      if (ctl.timing_clr) begin
        timing[ctl.waddr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pkt_we) begin
      pkt_mem[ctl.waddr] <= ctl.wpkt;
    end
    if (ctl.start_we) begin
      start_mem[ctl.waddr] <= ctl.wstart;
    end
    rd_pkt    <= pkt_mem[ctl.raddr];
    rd_start  <= start_mem[ctl.raddr];
    rd_timing <= timing[ctl.raddr];
  end

endmodule

@@ sv/go_back_n_sender_window_unit.sv @@
// Submit and rejected ack: busy stays low, result strobed next cycle; undefined op: no result.
// Accepted ack freeing n frames: busy until its n results are out, one result per cycle from the slot store port.
// Tick: a scan of up to 8 slot timers through the shared age compare, then on expiry with
// frames outstanding a prime state and one resend result per outstanding frame.
// Synchronous reset empties the window, stops all timers, zeroes time and loads
// window 7 and timeout 5; slot payloads are not cleared. Results cannot be stalled.
module go_back_n_sender_window_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [gbn_pkg::PKT_BITS-1:0]  packet_id,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq,
  output logic                          result_valid,
  output logic [2:0]                    kind,
  output logic [gbn_pkg::SEQ_BITS-1:0]  seq,
  output logic [gbn_pkg::PKT_BITS-1:0]  frame_packet,
  output logic                          last,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [gbn_pkg::CFG_BITS-1:0]  wr_data
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ACK, S_SCAN, S_PRIME, S_RESEND} state_t;

  state_t               state;
  logic [WIN_BITS-1:0]  window_size;
  logic [TIME_BITS-1:0] timeout_ticks;
  logic [SEQ_BITS-1:0]  oldest_unacked;
  logic [SEQ_BITS-1:0]  next_seq;
  logic [SEQ_BITS-1:0]  outstanding;
  logic [TIME_BITS-1:0] now;
  logic [SEQ_BITS-1:0]  ptr;
  logic [SEQ_BITS-1:0]  rem;
  logic [SEQ_BITS-1:0]  idx;

  mem_ctl_t             ctl;
  logic [PKT_BITS-1:0]  rd_pkt;
  logic [TIME_BITS-1:0] rd_start;
  logic                 rd_timing;

  logic [SEQ_BITS-1:0]  dist_ack;
  logic [SEQ_BITS-1:0]  dist_next;
  logic                 ack_ok;
  logic                 full;
  logic [TIME_BITS-1:0] age;
  logic                 expired_hit;
  logic [SEQ_BITS-1:0]  ptr_inc;

  gbn_slot_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_pkt    (rd_pkt),
    .rd_start  (rd_start),
    .rd_timing (rd_timing)
  );

  assign busy        = (state != S_IDLE);
  assign dist_ack    = SEQ_BITS'(ack_seq - oldest_unacked);
  assign dist_next   = SEQ_BITS'(next_seq - oldest_unacked);
  assign ack_ok      = (dist_ack < dist_next);
  assign full        = (outstanding >= window_size);
  assign age         = TIME_BITS'(now - rd_start);
  assign expired_hit = rd_timing && (age >= timeout_ticks);
  assign ptr_inc     = SEQ_BITS'(ptr + 1'b1);

  always_comb begin
    ctl        = '0;
    ctl.raddr  = oldest_unacked;
    ctl.waddr  = ptr;
    ctl.wpkt   = packet_id;
    ctl.wstart = now;
    case (state)
      S_IDLE: begin
        ctl.waddr = next_seq;
        if (op == OP_TICK) begin
          ctl.raddr = '0;
        end
        if (start && (op == OP_SUBMIT) && !full) begin
          ctl.pkt_we     = 1'b1;
          ctl.start_we   = 1'b1;
          ctl.timing_set = 1'b1;
        end
      end
      S_ACK: begin
        ctl.raddr      = ptr_inc;
        ctl.timing_clr = 1'b1;
      end
      S_SCAN: begin
        ctl.raddr = SEQ_BITS'(idx + 1'b1);
      end
      S_PRIME: begin
        ctl.raddr = oldest_unacked;
      end
      S_RESEND: begin
        ctl.raddr      = ptr_inc;
        ctl.start_we   = 1'b1;
        ctl.timing_set = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      window_size    <= WINDOW_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
      oldest_unacked <= '0;
      next_seq       <= '0;
      outstanding    <= '0;
      now            <= '0;
    end else begin
      result_valid <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_WINDOW:  window_size   <= wr_data[WIN_BITS-1:0];
          REG_TIMEOUT: timeout_ticks <= wr_data[TIME_BITS-1:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (op)
              OP_SUBMIT: begin
                result_valid <= 1'b1;
                seq          <= next_seq;
                frame_packet <= packet_id;
                last         <= 1'b1;
                if (full) begin
                  kind <= KIND_FULL;
                end else begin
                  kind        <= KIND_SEND;
                  next_seq    <= SEQ_BITS'(next_seq + 1'b1);
                  outstanding <= SEQ_BITS'(outstanding + 1'b1);
                end
              end
              OP_ACK: begin
                if (ack_ok) begin
                  ptr   <= oldest_unacked;
                  rem   <= SEQ_BITS'(dist_ack + 1'b1);
                  state <= S_ACK;
                end else begin
                  result_valid <= 1'b1;
                  kind         <= KIND_IGNORED;
                  seq          <= ack_seq;
                  frame_packet <= '0;
                  last         <= 1'b1;
                end
              end
              OP_TICK: begin
                idx   <= '0;
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_ACK: begin
          result_valid   <= 1'b1;
          kind           <= KIND_ACKED;
          seq            <= ptr;
          frame_packet   <= rd_pkt;
          last           <= (rem == SEQ_BITS'(1));
          if (outstanding != '0) begin
            outstanding <= SEQ_BITS'(outstanding - 1'b1);
          end
          oldest_unacked <= ptr_inc;
          ptr            <= ptr_inc;
          rem            <= SEQ_BITS'(rem - 1'b1);
          if (rem == SEQ_BITS'(1)) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (expired_hit && (outstanding != '0)) begin
            state <= S_PRIME;
          end else if (expired_hit || (idx == SEQ_BITS'(SEQ_COUNT - 1))) begin
            now   <= TIME_BITS'(now + 1'b1);
            state <= S_IDLE;
          end else begin
            idx <= SEQ_BITS'(idx + 1'b1);
          end
        end
        S_PRIME: begin
          ptr   <= oldest_unacked;
          rem   <= outstanding;
          state <= S_RESEND;
        end
        S_RESEND: begin
          result_valid <= 1'b1;
          kind         <= KIND_RESEND;
          seq          <= ptr;
          frame_packet <= rd_pkt;
          last         <= (rem == SEQ_BITS'(1));
          ptr          <= ptr_inc;
          rem          <= SEQ_BITS'(rem - 1'b1);
          if (rem == SEQ_BITS'(1)) begin
            next_seq <= ptr_inc;
            now      <= TIME_BITS'(now + 1'b1);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_window_count: assert property (@(posedge clk) disable iff (rst)
    outstanding == SEQ_BITS'(next_seq - oldest_unacked))
    else $error("outstanding count disagrees with window pointers");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_SEND || kind == KIND_FULL || kind == KIND_IGNORED)
      |-> last)
    else $error("single-word result without last");

  a_ack_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACK) |-> (outstanding != '0) && (rem != '0))
    else $error("ack walk on empty window");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && ($past(state) == S_ACK || $past(state) == S_RESEND)
      |-> result_valid && last)
    else $error("walk ended without last word");

endmodule
